### rtl/srms_pkg.sv
// Shared constants and types of the stereo RMS level meter.
`default_nettype none

package srms_pkg;

  localparam int SUM_W      = 42;
  localparam int CNT_W      = 13;
  localparam int AVG_W      = 24;
  localparam int BUF_W      = 16;
  localparam int ALPHA_W    = 17;
  localparam int FS_W       = 15;
  localparam int LVL_W      = 15;
  localparam int SCL_W      = 16;
  localparam int ROOT_W     = 21;
  localparam int DIV_W      = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam int PROD_W     = 43;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd4588;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [FS_W-1:0]    FS_RST    = 15'd5571;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ALPHA      = 2'd0,
    CFG_FULL_SCALE = 2'd1
  } cfg_addr_e;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SQ_L    = 9'b000000010,
    S_SQ_R    = 9'b000000100,
    S_MEAN    = 9'b000001000,
    S_ROOT    = 9'b000010000,
    S_AVG_MUL = 9'b000100000,
    S_AVG_ADD = 9'b001000000,
    S_SCALE   = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

### rtl/srms_if.sv
// Valid/ready channel interfaces of the stereo RMS level meter.
`default_nettype none

interface srms_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          last_frame;

  modport source (output valid, left_sample, right_sample, last_frame, input ready);
  modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface srms_out_if import srms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] rms_level;
  logic [LVL_W-1:0] smoothed_level;
  logic [SCL_W-1:0] scaled_level;
  logic [BUF_W-1:0] buffers_seen;

  modport source (output valid, rms_level, smoothed_level, scaled_level, buffers_seen,
                  input ready);
  modport sink   (input valid, rms_level, smoothed_level, scaled_level, buffers_seen,
                  output ready);
endinterface

interface srms_cfg_if import srms_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

### rtl/srms_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module srms_div import srms_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [SUM_W-1:0] quotient_o
);

  localparam int            CNT_BITS = $clog2(SUM_W);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(SUM_W - 1);

  logic                busy_q, done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [DIV_W-1:0]    rem_q, dvs_q, rem_d;
  logic [SUM_W-1:0]    quo_q;
  logic [DIV_W:0]      shifted, diff;
  logic                take;

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = shifted >= {1'b0, dvs_q};
  assign rem_d   = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SUM_W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/srms_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module srms_sqrt import srms_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  radicand_i,
  output logic                   done_o,
  output logic      [ROOT_W-1:0] root_o
);

  localparam int REM_W    = ROOT_W + 3;
  localparam int CNT_BITS = $clog2(ROOT_W);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(ROOT_W - 1);

  logic                busy_q, done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [SUM_W-1:0]    rad_q;
  logic [REM_W-1:0]    rem_q, rem_sh, trial;
  logic [ROOT_W-1:0]   root_q;
  logic                take;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SUM_W-1:SUM_W-2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= take ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### rtl/stereo_rms_level_meter.sv
// Stereo RMS level meter: top level with sequencer, accumulator and smoothing.
//
// Each stereo word is accepted in S_IDLE, then S_SQ_L and S_SQ_R pass one channel
// each through the shared squarer and 42-bit saturating accumulator. A word that
// closes a buffer (last_frame set, or MAX_FRAMES words reached) then runs the
// mean through the restoring divider, the square root, the moving average update
// (S_AVG_MUL, S_AVG_ADD) and the same divider again for the full-scale mapping
// before the result word is loaded into the output register. Input is not ready
// meanwhile. The result register lets the next buffer start while a
// result still waits downstream. Configuration is always ready.
`default_nettype none

module stereo_rms_level_meter import srms_pkg::*; #(
  parameter int MAX_FRAMES  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  srms_in_if.sink     data_in,
  srms_out_if.source  data_out,
  srms_cfg_if.sink    cfg
);

  localparam int MAG_W = SAMPLE_BITS - 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam logic [CNT_W-1:0] FRAMES_END = CNT_W'(MAX_FRAMES);

  state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] left_q, right_q, sel, half;
  logic                          last_q;
  logic [MAG_W-1:0]              mag;
  logic [SQ_W-1:0]               sq;
  logic [ACC_W-1:0]              sum_wide;
  logic [SUM_W-1:0]              sum_q, sum_sat;
  logic [CNT_W-1:0]              cnt_q, cnt_inc;
  logic                          buf_end;
  logic [AVG_W-1:0]              avg_q, avg_new;
  logic [BUF_W-1:0]              buf_q;
  logic [ALPHA_W-1:0]            alpha_q, alpha_eff;
  logic [FS_W-1:0]               fs_q, fs_eff;
  logic [LVL_W-1:0]              rms_q;
  logic signed [AVG_W:0]         diff;
  logic signed [PROD_W-1:0]      prod_d, prod_q, step;

  logic             div_start, div_done, sqrt_start, sqrt_done;
  logic [SUM_W-1:0] div_dividend, div_quot;
  logic [DIV_W-1:0] div_divisor;
  logic [ROOT_W-1:0] root;

  logic             out_valid_q, out_free;
  logic [LVL_W-1:0] out_rms_q, out_smooth_q;
  logic [SCL_W-1:0] out_scaled_q;
  logic [BUF_W-1:0] out_buf_q;

  // square and accumulate
  assign sel      = state_q == S_SQ_L ? left_q : right_q;
  assign half     = sel >>> 1;
  assign mag      = half[MAG_W-1] ? MAG_W'(-half) : half[MAG_W-1:0];
  assign sq       = SQ_W'(mag) * SQ_W'(mag);
  assign sum_wide = ACC_W'(sum_q) + ACC_W'(sq);
  assign sum_sat  = (|sum_wide[ACC_W-1:SUM_W]) ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign cnt_inc  = cnt_q + 1'b1;
  assign buf_end  = last_q || (cnt_inc >= FRAMES_END);

  // moving average
  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign diff      = $signed({2'b00, rms_q, 8'h00}) - $signed({1'b0, avg_q});
  assign prod_d    = $signed({1'b0, alpha_eff}) * diff;
  assign step      = prod_q >>> 16;
  assign avg_new   = avg_q + step[AVG_W-1:0];
  assign fs_eff    = (fs_q == '0) ? FS_W'(1) : fs_q;

  // shared divider operands
  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_sat;
    div_divisor  = DIV_W'({cnt_inc, 1'b0});
    if (state_q == S_SQ_R && buf_end) begin
      div_start = 1'b1;
    end else if (state_q == S_AVG_ADD) begin
      div_start    = 1'b1;
      div_dividend = SUM_W'({avg_new, 8'h00});
      div_divisor  = fs_eff;
    end
  end

  assign sqrt_start = state_q == S_MEAN && div_done;
  assign out_free   = !out_valid_q || data_out.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (data_in.valid) state_d = S_SQ_L;
      S_SQ_L:    state_d = S_SQ_R;
      S_SQ_R:    state_d = buf_end ? S_MEAN : S_IDLE;
      S_MEAN:    if (div_done) state_d = S_ROOT;
      S_ROOT:    if (sqrt_done) state_d = S_AVG_MUL;
      S_AVG_MUL: state_d = S_AVG_ADD;
      S_AVG_ADD: state_d = S_SCALE;
      S_SCALE:   if (div_done) state_d = S_EMIT;
      S_EMIT:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_q       <= '0;
      buf_q       <= '0;
      alpha_q     <= ALPHA_RST;
      fs_q        <= FS_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SQ_L) begin
        sum_q <= sum_sat;
      end
      if (state_q == S_SQ_R) begin
        sum_q <= buf_end ? '0 : sum_sat;
        cnt_q <= buf_end ? '0 : cnt_inc;
      end
      if (state_q == S_AVG_ADD) begin
        avg_q <= avg_new;
        buf_q <= buf_q + 1'b1;
      end
      if (cfg.valid) begin
        if (cfg.addr == CFG_ALPHA) begin
          alpha_q <= cfg.wdata;
        end else if (cfg.addr == CFG_FULL_SCALE) begin
          fs_q <= cfg.wdata[FS_W-1:0];
        end
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (data_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && data_in.valid) begin
      left_q  <= data_in.left_sample;
      right_q <= data_in.right_sample;
      last_q  <= data_in.last_frame;
    end
    if (state_q == S_ROOT && sqrt_done) begin
      rms_q <= (|root[ROOT_W-1:LVL_W]) ? {LVL_W{1'b1}} : root[LVL_W-1:0];
    end
    if (state_q == S_AVG_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_EMIT && out_free) begin
      out_rms_q    <= rms_q;
      out_smooth_q <= avg_q[LVL_W+7:8];
      out_scaled_q <= (|div_quot[SUM_W-1:SCL_W]) ? {SCL_W{1'b1}} : div_quot[SCL_W-1:0];
      out_buf_q    <= buf_q;
    end
  end

  srms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  srms_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quot),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  assign data_in.ready           = state_q == S_IDLE;
  assign cfg.ready               = 1'b1;
  assign data_out.valid          = out_valid_q;
  assign data_out.rms_level      = out_rms_q;
  assign data_out.smoothed_level = out_smooth_q;
  assign data_out.scaled_level   = out_scaled_q;
  assign data_out.buffers_seen   = out_buf_q;

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for the stereo RMS level meter: random framed audio against a level predictor.
`timescale 1ns / 1ps

module testbench import srms_pkg::*; ();

  localparam int MAX_FRAMES   = 256;
  localparam int SAMPLE_BITS  = 16;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int CALM_AFTER   = 560;
  localparam int TOTAL_FRAMES = 640;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0] rms;
    logic [LVL_W-1:0] smoothed;
    logic [SCL_W-1:0] scaled;
    logic [BUF_W-1:0] buffers;
  } level_t;

  class meter_scoreboard;
    logic [ALPHA_W-1:0] alpha;
    logic [FS_W-1:0]    full_scale;
    logic [SUM_W-1:0]   square_sum;
    int unsigned        frames;
    logic [AVG_W-1:0]   average;
    logic [BUF_W-1:0]   buffers;
    level_t             expected_levels[$];
    int                 errors;

    function new();
      alpha      = ALPHA_RST;
      full_scale = FS_RST;
      square_sum = '0;
      frames     = 0;
      average    = '0;
      buffers    = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ALPHA) begin
        alpha = data[ALPHA_W-1:0];
      end else if (idx == CFG_FULL_SCALE) begin
        full_scale = data[FS_W-1:0];
      end
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function longint unsigned half_square(logic signed [SAMPLE_BITS-1:0] s);
      longint h;
      h = longint'(s) >>> 1;
      return h * h;
    endfunction

    function void note_frame(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r,
                             logic last);
      longint unsigned sum_max;
      longint unsigned acc;
      longint unsigned mean;
      longint unsigned rms;
      longint unsigned fs;
      longint unsigned scaled;
      longint          weight;
      longint          diff;
      longint          step;
      longint          next_avg;
      level_t          lvl;
      sum_max = (64'd1 << SUM_W) - 1;
      acc = square_sum + half_square(l) + half_square(r);
      square_sum = (acc > sum_max) ? sum_max[SUM_W-1:0] : acc[SUM_W-1:0];
      frames++;
      if (!last && frames < MAX_FRAMES) return;

      mean = square_sum / (2 * frames);
      rms = root_floor(mean);
      if (rms > 32767) rms = 32767;

      weight = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
      diff = longint'(rms << 8) - longint'(average);
      step = (weight * diff) >>> 16;
      next_avg = longint'(average) + step;
      average = next_avg[AVG_W-1:0];

      fs = (full_scale == '0) ? 64'd1 : 64'(full_scale);
      scaled = (longint'(average) << 8) / fs;
      if (scaled > 65535) scaled = 65535;

      buffers++;
      lvl.rms      = rms[LVL_W-1:0];
      lvl.smoothed = average[LVL_W+7:8];
      lvl.scaled   = scaled[SCL_W-1:0];
      lvl.buffers  = buffers;
      expected_levels = {expected_levels, lvl};
      square_sum = '0;
      frames = 0;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_level(level_t got);
      level_t want;
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: unexpected level word rms %0d smoothed %0d scaled %0d buffers %0d",
                 $time, got.rms, got.smoothed, got.scaled, got.buffers);
        return;
      end
      want = expected_levels.pop_front();
      compare_field("rms_level", want.rms, got.rms);
      compare_field("smoothed_level", want.smoothed, got.smoothed);
      compare_field("scaled_level", want.scaled, got.scaled);
      compare_field("buffers_seen", want.buffers, got.buffers);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned sent_frames;
  meter_scoreboard sb = new();

  srms_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  srms_out_if out_if ();
  srms_cfg_if cfg_if ();

  stereo_rms_level_meter #(
    .MAX_FRAMES (MAX_FRAMES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .data_in (in_if),
    .data_out(out_if),
    .cfg     (cfg_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_frame(in_if.left_sample, in_if.right_sample, in_if.last_frame);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_level({out_if.rms_level, out_if.smoothed_level, out_if.scaled_level,
                      out_if.buffers_seen});
    end
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      sb.set_register(cfg_if.addr, cfg_if.wdata);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (calm) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int unsigned shift);
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0: s = 16'sh8000;
      1: s = 16'sh7FFF;
      default: begin
        s = SAMPLE_BITS'($urandom);
        s = s >>> shift;
      end
    endcase
    return s;
  endfunction

  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.left_sample  <= l;
    in_if.right_sample <= r;
    in_if.last_frame   <= last;
    do @(posedge clk); while (!in_if.ready);
    sent_frames++;
    calm = sent_frames >= CALM_AFTER;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic program_meter(input logic [CFG_DATA_W-1:0] alpha_word,
                               input logic [CFG_DATA_W-1:0] fs_word);
    write_reg(CFG_ALPHA, alpha_word);
    write_reg(CFG_FULL_SCALE, fs_word);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned frame_budget, input bit with_full_buffer);
    int unsigned start;
    int unsigned len;
    int unsigned shift;
    bit          broken;
    logic        last;
    start = sent_frames;
    while (sent_frames - start < frame_budget) begin
      broken = ($urandom_range(0, 9) == 0) && !with_full_buffer;
      shift = $urandom_range(0, 15);
      len = with_full_buffer ? MAX_FRAMES : $urandom_range(1, 12);
      with_full_buffer = 1'b0;
      for (int i = 1; i <= len; i++) begin
        if (broken) begin
          last = ($urandom_range(0, 3) == 0);
        end else begin
          last = (i == len) && (len != MAX_FRAMES);
        end
        send_frame(pick_sample(shift), pick_sample(shift), last);
      end
    end
    settle();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] alpha_word;
    in_if.valid        = 1'b0;
    in_if.left_sample  = '0;
    in_if.right_sample = '0;
    in_if.last_frame   = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.addr        = CFG_ALPHA;
    cfg_if.wdata       = '0;
    calm               = 1'b0;
    sent_frames        = 0;
    rst_n              = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b0);
    send_frame(16'sd0, 16'sd0, 1'b1);
    send_frame(16'sd1, -16'sd1, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b0);
    send_frame(-16'sd2, 16'sd3, 1'b1);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b0);
    send_frame(16'sd16384, -16'sd16385, 1'b1);
    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh7FFF, -16'sh7FFF, 1'b1);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b1);
    settle();

    program_meter(ALPHA_ONE, 17'd1);
    run_phase(100, 1'b1);

    program_meter(17'd0, 17'h07FFF);
    run_phase(90, 1'b0);

    program_meter(17'h1FFFF, 17'd0);
    run_phase(90, 1'b0);

    write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
    program_meter(CFG_DATA_W'($urandom_range(0, ALPHA_ONE)),
                  CFG_DATA_W'(17'h18000 | $urandom_range(0, 17'h7FFF)));
    run_phase(90, 1'b0);

    while (sent_frames < TOTAL_FRAMES) begin
      if ($urandom_range(0, 3) == 0) begin
        alpha_word = CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
      end else begin
        alpha_word = CFG_DATA_W'($urandom_range(0, ALPHA_ONE));
      end
      program_meter(alpha_word, CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
      run_phase(90, 1'b0);
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
